// ===== rtl/pfp_pkg.sv =====
// shared types and constants for the triangle plane setup block
`default_nettype none
package pfp_pkg;

    // normal outputs are signed q2.30
    localparam int NORM_W    = 32;
    localparam int NORM_FRAC = 30;

    // normalized component magnitudes have their top bit at bit 30
    localparam int MAG_W   = 31;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUMSQ_W = 64;
    localparam int ROOT_W  = 32;
    localparam int NDIV_W  = MAG_W + NORM_FRAC;

    // leading-one search granularity
    localparam int CHUNK_W = 8;

    // normal path: abs, chunk scan, chunk pick, shift, square, sum, root, divide, sign
    localparam int NORM_PRE = 6;
    localparam int NORM_LAT = NORM_PRE + ROOT_W + NDIV_W + 1;

    localparam int NUM_LANES = 3;

    typedef struct packed {
        logic vertical;
        logic degenerate;
    } t_flags;

    // width of one queued word: p1 x/y/z, determinant, two minors, flags
    function automatic int q_width(input int cw);
        return 3 * cw + 3 * (2 * (cw + 1) + 1) + $bits(t_flags);
    endfunction

endpackage
`default_nettype wire

// ===== rtl/pfp_in_if.sv =====
// input channel: three triangle corners
`default_nettype none
interface pfp_in_if #(parameter int CW = 32);
    logic          valid;
    logic          ready;
    logic signed [CW-1:0] p1_x;
    logic signed [CW-1:0] p1_y;
    logic signed [CW-1:0] p1_z;
    logic signed [CW-1:0] p2_x;
    logic signed [CW-1:0] p2_y;
    logic signed [CW-1:0] p2_z;
    logic signed [CW-1:0] p3_x;
    logic signed [CW-1:0] p3_y;
    logic signed [CW-1:0] p3_z;

    modport source (
        output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        input  ready
    );
    modport sink (
        input  valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/pfp_out_if.sv =====
// output channel: plane coefficients, unit normal and flags
`default_nettype none
interface pfp_out_if #(parameter int CW = 32);
    logic          valid;
    logic          ready;
    logic signed [CW-1:0] slope_x;
    logic signed [CW-1:0] slope_y;
    logic signed [CW-1:0] offset;
    logic signed [pfp_pkg::NORM_W-1:0] normal_x;
    logic signed [pfp_pkg::NORM_W-1:0] normal_y;
    logic signed [pfp_pkg::NORM_W-1:0] normal_z;
    logic          vertical_plane;
    logic          degenerate;

    modport source (
        output valid, slope_x, slope_y, offset, normal_x, normal_y, normal_z,
               vertical_plane, degenerate,
        input  ready
    );
    modport sink (
        input  valid, slope_x, slope_y, offset, normal_x, normal_y, normal_z,
               vertical_plane, degenerate,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/pfp_fifo.sv =====
// short register queue between the front and back halves
`default_nettype none
module pfp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_wdata,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_rdata,
    output logic              o_full,
    output logic              o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [W-1:0]    r_mem [DEPTH];
    logic [AW-1:0]   r_wptr;
    logic [AW-1:0]   r_rptr;
    logic [CNTW-1:0] r_cnt;

    assign o_full  = (r_cnt == CNTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNTW'(1);
                2'b01:   r_cnt <= r_cnt - CNTW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pfp_delay.sv =====
// enabled shift line that keeps side data in step with a pipelined unit
`default_nettype none
module pfp_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic [W-1:0]      o_q
);
    if (DEPTH == 0) begin : g_none
        assign o_q = i_d;
    end else begin : g_line
        logic [W-1:0] r_tap [DEPTH];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tap[0] <= i_d;
                for (int k = 1; k < DEPTH; k++) begin
                    r_tap[k] <= r_tap[k-1];
                end
            end
        end
        assign o_q = r_tap[DEPTH-1];
    end
endmodule
`default_nettype wire

// ===== rtl/pfp_div.sv =====
// unsigned restoring divider, one quotient bit per pipeline stage
`default_nettype none
module pfp_div #(
    parameter int NUM_W = 8,
    parameter int DEN_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0]      o_quo
);
    // numerator bits shift out the top while quotient bits fill in at the bottom
    logic [NUM_W-1:0] r_acc [1:NUM_W];
    logic [DEN_W-1:0] r_rem [1:NUM_W-1];
    logic [DEN_W-1:0] r_den [1:NUM_W-1];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0] acc_in;
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_acc;

        if (k == 0) begin : g_first
            assign acc_in = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign acc_in = r_acc[k];
            assign rem_in = r_rem[k];
            assign den_in = r_den[k];
        end

        assign trial = {rem_in, acc_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});
        assign n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        assign n_acc = {acc_in[NUM_W-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k+1] <= n_acc;
            end
        end

        if (k < NUM_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_rem;
                    r_den[k+1] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_acc[NUM_W];
endmodule
`default_nettype wire

// ===== rtl/pfp_sqrt.sv =====
// pipelined integer square root, one result bit per stage
`default_nettype none
module pfp_sqrt (
    input  wire logic [pfp_pkg::SUMSQ_W-1:0] i_s,
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    output logic [pfp_pkg::ROOT_W-1:0]       o_root
);
    import pfp_pkg::*;

    logic [SUMSQ_W-1:0] r_s   [1:ROOT_W-1];
    logic [SUMSQ_W-1:0] r_res [1:ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam logic [SUMSQ_W-1:0] BIT = SUMSQ_W'(1) << (SUMSQ_W - 2 - 2 * k);
        logic [SUMSQ_W-1:0] s_in;
        logic [SUMSQ_W-1:0] res_in;
        logic [SUMSQ_W-1:0] trial;
        logic               ge;

        if (k == 0) begin : g_first
            assign s_in   = i_s;
            assign res_in = '0;
        end else begin : g_next
            assign s_in   = r_s[k];
            assign res_in = r_res[k];
        end

        assign trial = res_in + BIT;
        assign ge    = (s_in >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[k+1] <= ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
            end
        end

        if (k < ROOT_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_s[k+1] <= ge ? (s_in - trial) : s_in;
                end
            end
        end
    end

    assign o_root = r_res[ROOT_W][ROOT_W-1:0];
endmodule
`default_nettype wire

// ===== rtl/pfp_front.sv =====
// front half: takes a triangle, forms edge vectors, determinant and minors, flags
`default_nettype none
module pfp_front #(
    parameter int CW = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    pfp_in_if.sink                             i_pts,
    input  wire logic                          i_full,
    output logic                               o_push,
    output logic [pfp_pkg::q_width(CW)-1:0]    o_word
);
    import pfp_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int KW = PW + 1;

    logic en;
    logic r_v1, r_v2, r_v3;

    logic signed [DW-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic signed [CW-1:0] r_x1_1, r_y1_1, r_z1_1;
    logic signed [CW-1:0] r_x1_2, r_y1_2, r_z1_2;
    logic signed [CW-1:0] r_x1_3, r_y1_3, r_z1_3;
    logic signed [PW-1:0] r_uxvy, r_uyvx, r_uzvy, r_uyvz, r_uxvz, r_uzvx;
    logic signed [KW-1:0] r_d, r_na, r_nb;
    t_flags               r_flags;

    logic [KW-1:0] n_d, n_na, n_nb;
    t_flags        n_flags;

    assign en          = !r_v3 || !i_full;
    assign i_pts.ready = en;
    assign o_push      = r_v3 && !i_full;
    assign o_word      = {r_x1_3, r_y1_3, r_z1_3, r_d, r_na, r_nb, r_flags};

    always_comb begin
        n_d  = {r_uxvy[PW-1], r_uxvy} - {r_uyvx[PW-1], r_uyvx};
        n_na = {r_uzvy[PW-1], r_uzvy} - {r_uyvz[PW-1], r_uyvz};
        n_nb = {r_uxvz[PW-1], r_uxvz} - {r_uzvx[PW-1], r_uzvx};
        n_flags.vertical   = (n_d == '0);
        n_flags.degenerate = (n_d == '0) && (n_na == '0) && (n_nb == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_pts.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // edge vectors relative to the third corner
            r_ux <= {i_pts.p1_x[CW-1], i_pts.p1_x} - {i_pts.p3_x[CW-1], i_pts.p3_x};
            r_uy <= {i_pts.p1_y[CW-1], i_pts.p1_y} - {i_pts.p3_y[CW-1], i_pts.p3_y};
            r_uz <= {i_pts.p1_z[CW-1], i_pts.p1_z} - {i_pts.p3_z[CW-1], i_pts.p3_z};
            r_vx <= {i_pts.p2_x[CW-1], i_pts.p2_x} - {i_pts.p3_x[CW-1], i_pts.p3_x};
            r_vy <= {i_pts.p2_y[CW-1], i_pts.p2_y} - {i_pts.p3_y[CW-1], i_pts.p3_y};
            r_vz <= {i_pts.p2_z[CW-1], i_pts.p2_z} - {i_pts.p3_z[CW-1], i_pts.p3_z};
            r_x1_1 <= i_pts.p1_x;
            r_y1_1 <= i_pts.p1_y;
            r_z1_1 <= i_pts.p1_z;

            r_uxvy <= r_ux * r_vy;
            r_uyvx <= r_uy * r_vx;
            r_uzvy <= r_uz * r_vy;
            r_uyvz <= r_uy * r_vz;
            r_uxvz <= r_ux * r_vz;
            r_uzvx <= r_uz * r_vx;
            r_x1_2 <= r_x1_1;
            r_y1_2 <= r_y1_1;
            r_z1_2 <= r_z1_1;

            r_d     <= n_d;
            r_na    <= n_na;
            r_nb    <= n_nb;
            r_flags <= n_flags;
            r_x1_3  <= r_x1_2;
            r_y1_3  <= r_y1_2;
            r_z1_3  <= r_z1_2;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pfp_back.sv =====
// back half: plane divisions and normal normalization, in step, into the output register
`default_nettype none
module pfp_back #(
    parameter int CW = 32,
    parameter int FB = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_empty,
    input  wire logic [pfp_pkg::q_width(CW)-1:0] i_word,
    output logic                               o_pop,
    pfp_out_if.source                          o_res
);
    import pfp_pkg::*;

    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int KW    = PW + 1;
    localparam int LH    = (KW + 1) / 2;
    localparam int HW    = KW - LH;
    localparam int ZW    = CW + KW;
    localparam int NWS   = KW + FB;
    localparam int NWC   = ZW + 2;
    localparam int NW    = (NWS > NWC) ? NWS : NWC;
    localparam int P_LAT = NW + 5;
    localparam int LAT   = (P_LAT > NORM_LAT) ? P_LAT : NORM_LAT;
    localparam int LW    = $clog2(KW + 1);
    localparam int NCH   = (KW + CHUNK_W - 1) / CHUNK_W;
    localparam int CLW   = $clog2(CHUNK_W + 1);
    localparam int PRW   = 3 * CW + 1;
    localparam int NRW   = 3 * NORM_W + 1;

    logic en;
    logic pop;
    logic [LAT-1:0] r_vld;

    logic signed [CW-1:0] u_x1, u_y1, u_z1;
    logic signed [KW-1:0] u_d, u_na, u_nb;
    t_flags               u_flags;

    assign {u_x1, u_y1, u_z1, u_d, u_na, u_nb, u_flags} = i_word;

    assign en    = !r_vld[LAT-1] || o_res.ready;
    assign pop   = !i_empty && en;
    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], pop};
        end
    end

    // ---------------- plane coefficients ----------------
    logic signed [CW+HW-1:0] r_b1_zd_hi, r_b1_nax_hi, r_b1_nby_hi;
    logic signed [CW+LH:0]   r_b1_zd_lo, r_b1_nax_lo, r_b1_nby_lo;
    logic signed [KW-1:0]    r_b1_d, r_b1_na, r_b1_nb;
    logic                    r_b1_vert;

    logic [ZW-1:0]           r_b2_zd, r_b2_nax, r_b2_nby;
    logic signed [KW-1:0]    r_b2_d, r_b2_na, r_b2_nb;
    logic                    r_b2_vert;

    logic [NW-1:0]           r_b3_num [NUM_LANES];
    logic [KW-1:0]           r_b3_d;
    logic                    r_b3_vert;

    logic [NW-1:0]           r_b4_mag [NUM_LANES];
    logic [KW-1:0]           r_b4_dmag;
    logic [NUM_LANES-1:0]    r_b4_neg;
    logic                    r_b4_vert;

    logic [NW-1:0]           w_q [NUM_LANES];
    logic [NUM_LANES-1:0]    w_q_neg;
    logic                    w_q_vert;
    logic [CW-1:0]           n_coef [NUM_LANES];
    logic [CW-1:0]           r_b5_coef [NUM_LANES];
    logic                    r_b5_vert;
    logic [PRW-1:0]          w_plane;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // wide products split into two narrower partial products
            r_b1_zd_hi  <= u_z1 * $signed(u_d[KW-1:LH]);
            r_b1_zd_lo  <= u_z1 * $signed({1'b0, u_d[LH-1:0]});
            r_b1_nax_hi <= u_x1 * $signed(u_na[KW-1:LH]);
            r_b1_nax_lo <= u_x1 * $signed({1'b0, u_na[LH-1:0]});
            r_b1_nby_hi <= u_y1 * $signed(u_nb[KW-1:LH]);
            r_b1_nby_lo <= u_y1 * $signed({1'b0, u_nb[LH-1:0]});
            r_b1_d      <= u_d;
            r_b1_na     <= u_na;
            r_b1_nb     <= u_nb;
            r_b1_vert   <= u_flags.vertical;

            r_b2_zd  <= {r_b1_zd_hi, {LH{1'b0}}}
                      + {{(HW-1){r_b1_zd_lo[CW+LH]}}, r_b1_zd_lo};
            r_b2_nax <= {r_b1_nax_hi, {LH{1'b0}}}
                      + {{(HW-1){r_b1_nax_lo[CW+LH]}}, r_b1_nax_lo};
            r_b2_nby <= {r_b1_nby_hi, {LH{1'b0}}}
                      + {{(HW-1){r_b1_nby_lo[CW+LH]}}, r_b1_nby_lo};
            r_b2_d    <= r_b1_d;
            r_b2_na   <= r_b1_na;
            r_b2_nb   <= r_b1_nb;
            r_b2_vert <= r_b1_vert;

            r_b3_num[0] <= {{(NW-KW){r_b2_na[KW-1]}}, r_b2_na} << FB;
            r_b3_num[1] <= {{(NW-KW){r_b2_nb[KW-1]}}, r_b2_nb} << FB;
            // offset numerator: z1*d - na*x1 - nb*y1
            r_b3_num[2] <= {{(NW-ZW){r_b2_zd[ZW-1]}}, r_b2_zd}
                         - {{(NW-ZW){r_b2_nax[ZW-1]}}, r_b2_nax}
                         - {{(NW-ZW){r_b2_nby[ZW-1]}}, r_b2_nby};
            r_b3_d    <= r_b2_d;
            r_b3_vert <= r_b2_vert;

            for (int i = 0; i < NUM_LANES; i++) begin
                r_b4_mag[i] <= r_b3_num[i][NW-1] ? (NW'(0) - r_b3_num[i]) : r_b3_num[i];
                r_b4_neg[i] <= r_b3_num[i][NW-1] ^ r_b3_d[KW-1];
            end
            r_b4_dmag <= r_b3_d[KW-1] ? (KW'(0) - r_b3_d) : r_b3_d;
            r_b4_vert <= r_b3_vert;

            r_b5_coef <= n_coef;
            r_b5_vert <= w_q_vert;
        end
    end

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_pdiv
        pfp_div #(.NUM_W(NW), .DEN_W(KW)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_b4_mag[i]),
            .i_den (r_b4_dmag),
            .o_quo (w_q[i])
        );
    end

    pfp_delay #(.W(NUM_LANES + 1), .DEPTH(NW)) u_psign (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_b4_neg, r_b4_vert}),
        .o_q   ({w_q_neg, w_q_vert})
    );

    // restore sign and saturate to the coordinate range; all zero for a vertical plane
    always_comb begin
        logic pos_ovf;
        logic neg_ovf;
        for (int i = 0; i < NUM_LANES; i++) begin
            pos_ovf = |w_q[i][NW-1:CW-1];
            neg_ovf = (|w_q[i][NW-1:CW]) || (w_q[i][CW-1] && (|w_q[i][CW-2:0]));
            if (w_q_vert) begin
                n_coef[i] = '0;
            end else if (w_q_neg[i]) begin
                n_coef[i] = neg_ovf ? {1'b1, {(CW-1){1'b0}}} : (CW'(0) - w_q[i][CW-1:0]);
            end else begin
                n_coef[i] = pos_ovf ? {1'b0, {(CW-1){1'b1}}} : w_q[i][CW-1:0];
            end
        end
    end

    pfp_delay #(.W(PRW), .DEPTH(LAT - P_LAT)) u_palign (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_b5_coef[0], r_b5_coef[1], r_b5_coef[2], r_b5_vert}),
        .o_q   (w_plane)
    );

    // ---------------- unit normal ----------------
    logic [KW-1:0]        r_n1_mag [NUM_LANES];
    logic [NUM_LANES-1:0] r_n1_neg;
    logic                 r_n1_deg;

    logic [KW-1:0]        r_n2_mag [NUM_LANES];
    logic [NCH-1:0]       r_n2_nz;
    logic [CLW-1:0]       r_n2_loc [NCH];
    logic [NCH-1:0]       n_n2_nz;
    logic [CLW-1:0]       n_n2_loc [NCH];

    logic [KW-1:0]        r_n3_mag [NUM_LANES];
    logic [LW-1:0]        r_n3_len;
    logic [LW-1:0]        n_n3_len;

    logic [MAG_W-1:0]     r_n4_m [NUM_LANES];
    logic [MAG_W-1:0]     n_n4_m [NUM_LANES];
    logic [SQ_W-1:0]      r_n5_sq [NUM_LANES];
    logic [MAG_W-1:0]     r_n5_m [NUM_LANES];
    logic [SUMSQ_W-1:0]   r_n6_s;
    logic [MAG_W-1:0]     r_n6_m [NUM_LANES];

    logic [ROOT_W-1:0]    w_root;
    logic [MAG_W-1:0]     w_m0, w_m1, w_m2;
    logic [MAG_W-1:0]     w_m [NUM_LANES];
    logic [NDIV_W-1:0]    w_nq [NUM_LANES];
    logic [NUM_LANES-1:0] w_nq_neg;
    logic                 w_nq_deg;
    logic [NORM_W-1:0]    n_norm [NUM_LANES];
    logic [NORM_W-1:0]    r_ne_norm [NUM_LANES];
    logic                 r_ne_deg;
    logic [NRW-1:0]       w_normal;

    always_comb begin
        logic [NCH*CHUNK_W-1:0] orv;
        orv = (NCH*CHUNK_W)'(r_n1_mag[0] | r_n1_mag[1] | r_n1_mag[2]);
        for (int c = 0; c < NCH; c++) begin
            n_n2_nz[c]  = |orv[c*CHUNK_W +: CHUNK_W];
            n_n2_loc[c] = '0;
            for (int b = 0; b < CHUNK_W; b++) begin
                if (orv[c*CHUNK_W + b]) begin
                    n_n2_loc[c] = CLW'(b + 1);
                end
            end
        end
    end

    // highest nonzero chunk gives the bit length
    always_comb begin
        n_n3_len = '0;
        for (int c = 0; c < NCH; c++) begin
            if (r_n2_nz[c]) begin
                n_n3_len = LW'(c * CHUNK_W) + LW'(r_n2_loc[c]);
            end
        end
    end

    // common shift so the largest magnitude has its top bit at bit 30
    always_comb begin
        logic [KW-1:0] rs;
        for (int i = 0; i < NUM_LANES; i++) begin
            rs = r_n3_mag[i] >> (r_n3_len - LW'(MAG_W));
            if (r_n3_len > LW'(MAG_W)) begin
                n_n4_m[i] = rs[MAG_W-1:0];
            end else begin
                n_n4_m[i] = r_n3_mag[i][MAG_W-1:0] << (LW'(MAG_W) - r_n3_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n1_mag[0] <= u_na[KW-1] ? (KW'(0) - u_na) : u_na;
            r_n1_mag[1] <= u_nb[KW-1] ? (KW'(0) - u_nb) : u_nb;
            r_n1_mag[2] <= u_d[KW-1] ? (KW'(0) - u_d) : u_d;
            // z component is -d: negative when d is positive
            r_n1_neg <= {!u_d[KW-1] && !u_flags.vertical, u_nb[KW-1], u_na[KW-1]};
            r_n1_deg <= u_flags.degenerate;

            r_n2_mag <= r_n1_mag;
            r_n2_nz  <= n_n2_nz;
            r_n2_loc <= n_n2_loc;

            r_n3_mag <= r_n2_mag;
            r_n3_len <= n_n3_len;

            r_n4_m <= n_n4_m;

            for (int i = 0; i < NUM_LANES; i++) begin
                r_n5_sq[i] <= r_n4_m[i] * r_n4_m[i];
            end
            r_n5_m <= r_n4_m;

            r_n6_s <= SUMSQ_W'(r_n5_sq[0]) + SUMSQ_W'(r_n5_sq[1]) + SUMSQ_W'(r_n5_sq[2]);
            r_n6_m <= r_n5_m;

            r_ne_norm <= n_norm;
            r_ne_deg  <= w_nq_deg;
        end
    end

    pfp_sqrt u_sqrt (
        .i_s    (r_n6_s),
        .i_clk  (i_clk),
        .i_en   (en),
        .o_root (w_root)
    );

    pfp_delay #(.W(NUM_LANES * MAG_W), .DEPTH(ROOT_W)) u_mdelay (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_n6_m[0], r_n6_m[1], r_n6_m[2]}),
        .o_q   ({w_m0, w_m1, w_m2})
    );

    assign w_m[0] = w_m0;
    assign w_m[1] = w_m1;
    assign w_m[2] = w_m2;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_ndiv
        pfp_div #(.NUM_W(NDIV_W), .DEN_W(ROOT_W)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num ({w_m[i], {NORM_FRAC{1'b0}}}),
            .i_den (w_root),
            .o_quo (w_nq[i])
        );
    end

    pfp_delay #(.W(NUM_LANES + 1), .DEPTH(NORM_LAT - 2)) u_nsign (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_n1_neg, r_n1_deg}),
        .o_q   ({w_nq_neg, w_nq_deg})
    );

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (w_nq_deg) begin
                n_norm[i] = '0;
            end else if (w_nq_neg[i]) begin
                n_norm[i] = NORM_W'(0) - w_nq[i][NORM_W-1:0];
            end else begin
                n_norm[i] = w_nq[i][NORM_W-1:0];
            end
        end
    end

    pfp_delay #(.W(NRW), .DEPTH(LAT - NORM_LAT)) u_nalign (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   ({r_ne_norm[0], r_ne_norm[1], r_ne_norm[2], r_ne_deg}),
        .o_q   (w_normal)
    );

    assign o_res.valid = r_vld[LAT-1];
    assign {o_res.slope_x, o_res.slope_y, o_res.offset, o_res.vertical_plane} = w_plane;
    assign {o_res.normal_x, o_res.normal_y, o_res.normal_z, o_res.degenerate} = w_normal;
endmodule
`default_nettype wire

// ===== rtl/plane_from_three_points_top.sv =====
// triangle plane setup: slopes, offset and unit normal from three corners
// throughput: one triangle per cycle while the output side takes words
// pipeline: 3 front stages, the queue, then max(plane divider depth + 5, 100-stage
//   normal path) back stages
// the back pipeline depth is set by the one-bit-per-stage dividers and the root unit
// reset: synchronous active low, empties the pipeline valids and the queue; no other state
`default_nettype none
module plane_from_three_points_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pfp_in_if.sink     i_pts,
    pfp_out_if.source  o_res
);
    import pfp_pkg::*;

    localparam int QW = q_width(COORD_WIDTH);

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    logic [QW-1:0] w_wword;
    logic [QW-1:0] w_rword;

    pfp_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pts   (i_pts),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_word  (w_wword)
    );

    pfp_fifo #(.W(QW), .DEPTH(2)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wword),
        .i_pop   (w_pop),
        .o_rdata (w_rword),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    pfp_back #(.CW(COORD_WIDTH), .FB(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_word  (w_rword),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );
endmodule
`default_nettype wire
